/* design/crc_framed_register_access_master_defines.svh */
// Assertion helpers used by crfam_ctrl; clocked on clk, disabled while rst_n is low.
`ifndef CRC_FRAMED_REGISTER_ACCESS_MASTER_DEFINES_SVH
`define CRC_FRAMED_REGISTER_ACCESS_MASTER_DEFINES_SVH

// Same-cycle implication.
`define CRFAM_ASSERT_IMPL(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Next-cycle implication.
`define CRFAM_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

/* design/crfam_pkg.sv */
`default_nettype none

package crfam_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RESP  = 2'd2;

    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    localparam logic [7:0] CRC_POLY        = 8'h07;
    localparam logic [7:0] NO_ADDR         = 8'hFF;
    localparam logic [7:0] READ_ADDR_MASK  = 8'hFE;
    localparam logic [2:0] MAX_ATTEMPTS_RESET = 3'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  address;
        logic [15:0] write_data;
        logic [31:0] rx_frame;
        logic [7:0]  rx_check;
        logic        rx_ok;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] tx_frame;
        logic [7:0]  tx_check;
        logic [31:0] read_data;
    } out_item_t;

    // Bit-serial CRC-8, MSB first; used only to build the parity masks below.
    function automatic logic [7:0] crc8_serial(input logic [31:0] w);
        logic [7:0] c;
        c = '0;
        for (int b = 3; b >= 0; b--)
        begin
            c = c ^ w[8*b +: 8];
            for (int i = 0; i < 8; i++)
            begin
                c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // CRC bit j is the parity of the word bits selected by mask j.
    function automatic logic [7:0][31:0] crc8_masks();
        logic [7:0][31:0] m;
        logic [7:0]       c;
        m = '0;
        for (int k = 0; k < 32; k++)
        begin
            c = crc8_serial(32'(1) << k);
            for (int j = 0; j < 8; j++)
            begin
                m[j][k] = c[j];
            end
        end
        return m;
    endfunction

    localparam logic [7:0][31:0] CRC_MASKS = crc8_masks();

    function automatic logic [31:0] frame_of(input logic [7:0] rd, input logic [7:0] wr,
                                             input logic [15:0] val);
        logic [7:0] b0;
        b0 = (rd == NO_ADDR) ? NO_ADDR : (rd & READ_ADDR_MASK);
        return {b0, wr, val[7:0], val[15:8]};
    endfunction

endpackage

`default_nettype wire

/* design/crc_framed_register_access_master.sv */
// Datapath: an accepted item is captured in the input register, which feeds the result
// register through one level of logic; items that cause no result leave nothing behind.
// Throughput: one item per cycle; the combinational CRC-8 parity tree and
// phase update set that figure, and out_stall holds both stages.
// Reset: asynchronous, clears both valid flags, returns the phase to idle and
// loads max_attempts with 3.
`default_nettype none

module crc_framed_register_access_master (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 config_write,
    input  wire logic [2:0]           config_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire crfam_pkg::in_item_t  in_item,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output crfam_pkg::out_item_t      out_item
);

    logic                  s1_valid_reg;
    crfam_pkg::in_item_t   s1_item_reg;
    logic                  out_valid_reg;
    crfam_pkg::out_item_t  out_item_reg;

    logic                  out_free;
    logic                  res_valid;
    crfam_pkg::out_item_t  res;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !out_free;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    crfam_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .config_write (config_write),
        .config_data  (config_data),
        .item_valid   (s1_valid_reg),
        .item         (s1_item_reg),
        .advance      (out_free),
        .result_valid (res_valid),
        .result       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg && res_valid;
            end
        end
    end

    // payload registers: input loads on transfer, output loads whenever free; hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_item_reg <= in_item;
        end
        if (out_free)
        begin
            out_item_reg <= res;
        end
    end

endmodule

`default_nettype wire

/* design/crfam_crc8.sv */
`default_nettype none

module crfam_crc8 (
    input  wire logic [31:0] data,
    output logic      [7:0]  crc
);

    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            crc[j] = ^(data & crfam_pkg::CRC_MASKS[j]);
        end
    end

endmodule

`default_nettype wire

/* design/crfam_ctrl.sv */
`default_nettype none
`include "crc_framed_register_access_master_defines.svh"

module crfam_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 config_write,
    input  wire logic [2:0]           config_data,
    input  wire logic                 item_valid,
    input  wire crfam_pkg::in_item_t  item,
    input  wire logic                 advance,
    output logic                      result_valid,
    output crfam_pkg::out_item_t      result
);

    typedef enum logic [1:0] {PH_IDLE, PH_WRITE, PH_ADDR, PH_FETCH} phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  attempts_done_reg, attempts_done_next;
    logic [7:0]  held_address_reg, held_address_next;
    logic [15:0] held_value_reg, held_value_next;
    logic [2:0]  max_attempts_reg;

    logic [7:0]  rx_crc;
    logic [7:0]  tx_crc;
    logic [31:0] tx_frame;
    logic [1:0]  kind;
    logic [31:0] read_data;
    logic        good;
    logic        is_write;
    logic [15:0] cmd_value;

    crfam_crc8 u_rx_crc (.data(item.rx_frame), .crc(rx_crc));
    crfam_crc8 u_tx_crc (.data(tx_frame),      .crc(tx_crc));

    always_comb
    begin
        phase_next         = phase_reg;
        attempts_done_next = attempts_done_reg;
        held_address_next  = held_address_reg;
        held_value_next    = held_value_reg;
        result_valid       = 1'b0;
        kind               = crfam_pkg::KIND_SEND;
        tx_frame           = '0;
        read_data          = '0;
        good               = item.rx_ok && (rx_crc == item.rx_check);
        is_write           = (item.op == crfam_pkg::OP_WRITE);
        cmd_value          = is_write ? item.write_data : 16'd0;

        if (item_valid)
        begin
            if ((item.op == crfam_pkg::OP_READ || is_write) && phase_reg == PH_IDLE)
            begin
                held_address_next  = item.address;
                held_value_next    = cmd_value;
                attempts_done_next = 3'd1;
                phase_next         = is_write ? PH_WRITE : PH_ADDR;
                result_valid       = 1'b1;
                tx_frame           = is_write
                    ? crfam_pkg::frame_of(crfam_pkg::NO_ADDR, item.address, cmd_value)
                    : crfam_pkg::frame_of(item.address, crfam_pkg::NO_ADDR, 16'd0);
            end
            else if (item.op == crfam_pkg::OP_RESP && phase_reg != PH_IDLE)
            begin
                result_valid = 1'b1;
                if (!good)
                begin
                    if (attempts_done_reg >= max_attempts_reg)
                    begin
                        phase_next = PH_IDLE;
                        kind       = crfam_pkg::KIND_FAIL;
                    end
                    else
                    begin
                        // restart the whole operation
                        attempts_done_next = 3'(attempts_done_reg + 3'd1);
                        if (phase_reg == PH_WRITE)
                        begin
                            tx_frame = crfam_pkg::frame_of(crfam_pkg::NO_ADDR,
                                                           held_address_reg, held_value_reg);
                        end
                        else
                        begin
                            phase_next = PH_ADDR;
                            tx_frame   = crfam_pkg::frame_of(held_address_reg,
                                                             crfam_pkg::NO_ADDR, 16'd0);
                        end
                    end
                end
                else
                begin
                    unique case (phase_reg)
                        PH_ADDR:
                        begin
                            phase_next = PH_FETCH;
                            tx_frame   = crfam_pkg::frame_of(crfam_pkg::NO_ADDR,
                                                             crfam_pkg::NO_ADDR, 16'd0);
                        end
                        PH_FETCH:
                        begin
                            phase_next = PH_IDLE;
                            kind       = crfam_pkg::KIND_OK;
                            read_data  = {item.rx_frame[7:0], item.rx_frame[15:8],
                                          item.rx_frame[23:16], item.rx_frame[31:24]};
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                            kind       = crfam_pkg::KIND_OK;
                        end
                    endcase
                end
            end
        end

        result.kind      = kind;
        result.tx_frame  = tx_frame;
        result.tx_check  = (kind == crfam_pkg::KIND_SEND) ? tx_crc : 8'd0;
        result.read_data = read_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            attempts_done_reg <= '0;
            held_address_reg  <= '0;
            held_value_reg    <= '0;
            max_attempts_reg  <= crfam_pkg::MAX_ATTEMPTS_RESET;
        end
        else
        begin
            if (item_valid && advance)
            begin
                phase_reg         <= phase_next;
                attempts_done_reg <= attempts_done_next;
                held_address_reg  <= held_address_next;
                held_value_reg    <= held_value_next;
            end
            if (config_write)
            begin
                max_attempts_reg <= config_data;
            end
        end
    end

    `CRFAM_ASSERT_IMPL(a_busy_has_attempt, phase_reg != PH_IDLE, attempts_done_reg != 3'd0)
    `CRFAM_ASSERT_IMPL(a_fetch_value_zero, phase_reg == PH_FETCH, held_value_reg == 16'd0)
    `CRFAM_ASSERT_NEXT(a_idle_holds, phase_reg == PH_IDLE && !(item_valid && advance),
                       phase_reg == PH_IDLE)
    `CRFAM_ASSERT_IMPL(a_resp_answers,
                       item_valid && item.op == crfam_pkg::OP_RESP && phase_reg != PH_IDLE,
                       result_valid)

endmodule

`default_nettype wire
